// File: sv/tpq_pkg.sv
package tpq_pkg;

  // Sizes
  localparam int CLASS_DEPTH = 32;
  localparam int STACK_DEPTH = 128;
  localparam int LENGTH_BITS = 16;

  localparam int CLASS_IDX_W = $clog2(CLASS_DEPTH);
  localparam int CLASS_CNT_W = $clog2(CLASS_DEPTH + 1);
  localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
  localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int QUEUE_CNT_W = $clog2(2 * CLASS_DEPTH + 1);

  // Action codes
  localparam logic ACT_SUBMIT = 1'b0;
  localparam logic ACT_ACCEPT = 1'b1;

  // Status codes
  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_RECORDED = 3'd4;

  typedef logic [LENGTH_BITS-1:0] len_t;

  // Request payload
  typedef struct packed {
    logic        action;
    logic        premium;
    logic [15:0] code_length;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] runtime_value;
    logic [7:0]  stack_count;
    logic [6:0]  queued_count;
  } out_item_t;

  // Class FIFO control and status
  typedef struct packed {
    logic push;
    logic pop;
    len_t wdata;
  } fifo_ctl_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [CLASS_CNT_W-1:0] fill;
    len_t                   head_data;
  } fifo_stat_t;

  // Runtime stack control and status
  typedef struct packed {
    logic push;
    len_t wdata;
  } stack_ctl_t;

  typedef struct packed {
    logic                   full;
    logic [STACK_CNT_W-1:0] fill;
  } stack_stat_t;

endpackage

// File: sv/tpq_class_fifo.sv
module tpq_class_fifo
  import tpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_ctl_t  ctl,
  output fifo_stat_t stat
);

  len_t                   mem [CLASS_DEPTH];
  logic [CLASS_IDX_W-1:0] head_r, head_nxt;
  logic [CLASS_CNT_W-1:0] fill_r, fill_nxt;
  logic [CLASS_IDX_W:0]   tail_sum;
  logic [CLASS_IDX_W-1:0] tail;

  // Tail slot: head plus fill, wrapped at the depth
  always_comb begin
    tail_sum = {1'b0, head_r} + (CLASS_IDX_W + 1)'(fill_r);
    if (tail_sum >= (CLASS_IDX_W + 1)'(CLASS_DEPTH)) begin
      tail_sum = tail_sum - (CLASS_IDX_W + 1)'(CLASS_DEPTH);
    end
    tail = tail_sum[CLASS_IDX_W-1:0];
  end

  // Pointer and fill updates
  always_comb begin
    head_nxt = head_r;
    if (ctl.pop) begin
      head_nxt = (head_r == CLASS_IDX_W'(CLASS_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    fill_nxt = fill_r + CLASS_CNT_W'(ctl.push) - CLASS_CNT_W'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= ctl.wdata;
    end
  end

  assign stat.full      = (fill_r >= CLASS_CNT_W'(CLASS_DEPTH));
  assign stat.empty     = (fill_r == '0);
  assign stat.fill      = fill_r;
  assign stat.head_data = mem[head_r];

endmodule

// File: sv/tpq_runtime_stack.sv
module tpq_runtime_stack
  import tpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  stack_ctl_t  ctl,
  output stack_stat_t stat
);

  len_t                   mem [STACK_DEPTH];
  logic [STACK_CNT_W-1:0] fill_r, fill_nxt;

  assign fill_nxt = fill_r + STACK_CNT_W'(ctl.push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Push at the top slot
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[fill_r[STACK_IDX_W-1:0]] <= ctl.wdata;
    end
  end

  assign stat.full = (fill_r >= STACK_CNT_W'(STACK_DEPTH));
  assign stat.fill = fill_r;

endmodule

// File: sv/two_class_priority_queue_with_stack_core.sv
// Channel   Direction  Handshake          Payload
// in_       request    in_valid/in_stall  in_item_t (action, premium, code_length)
// out_      result     out_valid/out_stall out_item_t (status, runtime, counts)
//
// One request per cycle sustained while out_stall is low; each request is held
// in the input register, then its result in the result register.
// Synchronous active-low reset clears FIFO pointers, fill counts and the
// stack count; FIFO and stack contents are left as they are.
// out_stall holds the result register; the input stalls only when both
// the input register and the result register are occupied and held.
module two_class_priority_queue_with_stack_core
  import tpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_data_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;
  out_item_t   result;
  logic        advance;
  logic        go;

  fifo_ctl_t   p_ctl, o_ctl;
  fifo_stat_t  p_stat, o_stat;
  stack_ctl_t  s_ctl;
  stack_stat_t s_stat;

  len_t                   req_len;
  len_t                   pop_data;
  logic [CLASS_CNT_W-1:0] p_after, o_after;
  logic [STACK_CNT_W-1:0] s_after;
  logic [QUEUE_CNT_W-1:0] q_after;

  tpq_class_fifo u_premium (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (p_ctl),
    .stat (p_stat)
  );

  tpq_class_fifo u_ordinary (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (o_ctl),
    .stat (o_stat)
  );

  tpq_runtime_stack u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (s_ctl),
    .stat (s_stat)
  );

  // Handshake: the result register frees up when empty or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign go       = s1_valid_r && advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && !in_stall) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  // Request decode and queue/stack control
  always_comb begin
    req_len       = s1_data_r.code_length[LENGTH_BITS-1:0];
    p_ctl         = '0;
    o_ctl         = '0;
    s_ctl         = '0;
    p_ctl.wdata   = req_len;
    o_ctl.wdata   = req_len;
    pop_data      = '0;
    result        = '0;
    result.status = ST_QUEUED;

    if (s1_data_r.action == ACT_SUBMIT) begin
      if (s1_data_r.premium) begin
        p_ctl.push = go && !p_stat.full;
        result.status = p_stat.full ? ST_FULL : ST_QUEUED;
      end else begin
        o_ctl.push = go && !o_stat.full;
        result.status = o_stat.full ? ST_FULL : ST_QUEUED;
      end
    end else if (p_stat.empty && o_stat.empty) begin
      result.status = ST_EMPTY;
    end else begin
      // Premium class always served first
      if (!p_stat.empty) begin
        p_ctl.pop = go;
        pop_data  = p_stat.head_data;
      end else begin
        o_ctl.pop = go;
        pop_data  = o_stat.head_data;
      end
      s_ctl.wdata = pop_data;
      if (s_stat.full) begin
        result.status = ST_OVERFLOW;
      end else begin
        s_ctl.push    = go;
        result.status = ST_RECORDED;
      end
    end

    // Counts after this request
    p_after = p_stat.fill + CLASS_CNT_W'(p_ctl.push) - CLASS_CNT_W'(p_ctl.pop);
    o_after = o_stat.fill + CLASS_CNT_W'(o_ctl.push) - CLASS_CNT_W'(o_ctl.pop);
    s_after = s_stat.fill + STACK_CNT_W'(s_ctl.push);
    q_after = QUEUE_CNT_W'(p_after) + QUEUE_CNT_W'(o_after);

    result.runtime_value = 16'(pop_data);
    result.stack_count   = 8'(s_after);
    result.queued_count  = 7'(q_after);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (go) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Never pop both classes for one request
  a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(p_ctl.pop && o_ctl.pop))
    else $error("both class queues popped at once");

  // Ordinary class served only when premium is empty
  a_priority: assert property (@(posedge clk) disable iff (!rst_n)
    o_ctl.pop |-> p_stat.empty)
    else $error("ordinary request served ahead of premium");

  // Stack push only on a pop that was not an overflow
  a_stack_push: assert property (@(posedge clk) disable iff (!rst_n)
    s_ctl.push |-> ((p_ctl.pop || o_ctl.pop) && !s_stat.full))
    else $error("stack pushed without a dequeued request");

  // An empty report leaves nothing queued and no runtime
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_EMPTY) |->
      (out_data_r.runtime_value == '0 && out_data_r.queued_count == '0))
    else $error("empty status with non-zero runtime or queue count");
`endif

endmodule
